/* rtl/l2h_pkg.sv */
// Shared types, constants and helpers for the log2 latency histogram.
// No dependencies; imported by l2h_outq, the top module and the testbench.
package l2h_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int NBUCKETS    = SAMPLE_BITS + 1;
    localparam int IDX_W       = $clog2(NBUCKETS);
    localparam int IN_SMP_W    = 32;
    localparam int SEL_W       = 6;
    localparam int CNT_W       = 32;
    localparam int SUM_W       = 64;
    localparam int IN_DATA_W   = 40;

    localparam logic [IN_SMP_W-1:0] SMP_MASK =
        (SAMPLE_BITS >= IN_SMP_W) ? {IN_SMP_W{1'b1}}
                                  : IN_SMP_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
    } t_entry;

    // first field of the output beat sits in the high bits
    typedef struct packed {
        logic [SUM_W-1:0] all_sum;
        logic [CNT_W-1:0] all_count;
        logic [SUM_W-1:0] bucket_sum;
        logic [CNT_W-1:0] bucket_count;
    } t_result;

    function automatic logic [IDX_W-1:0] f_bit_length(input logic [IN_SMP_W-1:0] v);
        logic [IDX_W-1:0] n;
        n = '0;
        for (int i = 0; i < IN_SMP_W; i++) begin
            if (v[i]) begin
                n = IDX_W'(i + 1);
            end
        end
        return n;
    endfunction

    function automatic logic [CNT_W-1:0] f_sat_inc(input logic [CNT_W-1:0] c);
        return (&c) ? c : c + CNT_W'(1);
    endfunction

    function automatic logic [SUM_W-1:0] f_sat_add(input logic [SUM_W-1:0] a,
                                                   input logic [IN_SMP_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W + 1 - IN_SMP_W){1'b0}}, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

/* rtl/l2h_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module l2h_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/l2h_outq.sv */
// Two-entry result queue in front of the master stream port.
// Depends on l2h_pkg for the result beat type.
module l2h_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  l2h_pkg::t_result i_data,
    input  logic             i_pop,
    output l2h_pkg::t_result o_head,
    output logic             o_valid,
    output logic [1:0]       o_count
);
    import l2h_pkg::*;

    t_result    r_q0;
    t_result    r_q1;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        unique case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // payload: head is always r_q0
    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            r_q0 <= (i_push && r_cnt == 2'd1) ? i_data : r_q1;
            if (i_push && r_cnt == 2'd2) begin
                r_q1 <= i_data;
            end
        end else if (i_push) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= i_data;
            end else begin
                r_q1 <= i_data;
            end
        end
    end

    assign o_head  = r_q0;
    assign o_valid = (r_cnt != 2'd0);
    assign o_count = r_cnt;

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_cnt == 2'd2) |-> i_pop)
        else $error("push into full result queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != 2'd0))
        else $error("pop from empty result queue");

endmodule

/* rtl/log2_latency_histogram.sv */
// Latency histogram top: index stage, bucket RAM read-modify-write, totals.
// Depends on l2h_pkg, l2h_ram and l2h_outq.
// Throughput: one beat per cycle; registered bucket read plus forwarding of the previous
//   cycle's write; input stalls only while the result queue is backed up.
// A read beat passes the RAM stage registers and then the result queue to the master port.
// Reset (sync, active low) clears totals, 33 valid bits and the result queue.
module log2_latency_histogram (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [l2h_pkg::IN_DATA_W-1:0] i_s_tdata,  // sample[31:0], bucket_sel[37:32], pad
    input  logic                          i_s_tuser,  // mode
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [$bits(l2h_pkg::t_result)-1:0] o_m_tdata
    // o_m_tdata: bucket_count[31:0], bucket_sum[95:32], all_count[127:96], all_sum[191:128]
);
    import l2h_pkg::*;

    // index stage
    logic                accept;
    logic [IN_SMP_W-1:0] w_sample;
    logic [SEL_W-1:0]    w_sel;
    logic [IDX_W-1:0]    w_idx;
    logic                w_inrange;

    // RAM stage
    logic                r_s1_valid;
    logic                r_s1_mode;
    logic [IN_SMP_W-1:0] r_s1_sample;
    logic [IDX_W-1:0]    r_s1_idx;
    logic                r_s1_inrange;
    logic [NBUCKETS-1:0] r_vld;
    logic [NBUCKETS-1:0] n_vld;
    logic                r_w_valid;
    logic [IDX_W-1:0]    r_w_idx;
    t_entry              r_w_data;
    logic [CNT_W-1:0]    r_all_count;
    logic [SUM_W-1:0]    r_all_sum;

    t_entry     ram_rdata;
    t_entry     cur;
    t_entry     upd;
    logic       we;
    logic       push;
    logic       pop;
    t_result    res;
    t_result    q_head;
    logic       q_valid;
    logic [1:0] q_cnt;
    logic [2:0] pend;

    assign accept   = i_s_tvalid && o_s_tready;
    assign w_sample = i_s_tdata[IN_SMP_W-1:0] & SMP_MASK;
    assign w_sel    = i_s_tdata[IN_SMP_W+SEL_W-1:IN_SMP_W];

    always_comb begin
        if (i_s_tuser == MODE_ADD) begin
            w_idx     = f_bit_length(w_sample);
            w_inrange = 1'b1;
        end else begin
            w_inrange = ({26'd0, w_sel} < NBUCKETS);
            w_idx     = w_inrange ? w_sel[IDX_W-1:0] : '0;
        end
    end

    l2h_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (NBUCKETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_s1_idx),
        .i_wdata (upd),
        .i_re    (accept),
        .i_raddr (w_idx),
        .o_rdata (ram_rdata)
    );

    // last cycle's write is not yet visible in the registered read data
    always_comb begin
        if (!r_s1_inrange) begin
            cur = '0;
        end else if (r_w_valid && r_w_idx == r_s1_idx) begin
            cur = r_w_data;
        end else if (r_vld[r_s1_idx]) begin
            cur = ram_rdata;
        end else begin
            cur = '0;
        end
    end

    assign upd.cnt = f_sat_inc(cur.cnt);
    assign upd.sum = f_sat_add(cur.sum, r_s1_sample);
    assign we      = r_s1_valid && (r_s1_mode == MODE_ADD);
    assign push    = r_s1_valid && (r_s1_mode == MODE_READ);

    always_comb begin
        n_vld = r_vld;
        if (we) begin
            n_vld[r_s1_idx] = 1'b1;
        end
    end

    assign res.bucket_count = cur.cnt;
    assign res.bucket_sum   = cur.sum;
    assign res.all_count    = r_all_count;
    assign res.all_sum      = r_all_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_w_valid   <= 1'b0;
            r_vld       <= '0;
            r_all_count <= '0;
            r_all_sum   <= '0;
        end else begin
            r_s1_valid <= accept;
            r_w_valid  <= we;
            r_vld      <= n_vld;
            if (we) begin
                r_all_count <= f_sat_inc(r_all_count);
                r_all_sum   <= f_sat_add(r_all_sum, r_s1_sample);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_mode    <= i_s_tuser;
            r_s1_sample  <= w_sample;
            r_s1_idx     <= w_idx;
            r_s1_inrange <= w_inrange;
        end
        r_w_idx  <= r_s1_idx;
        r_w_data <= upd;
    end

    l2h_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res),
        .i_pop   (pop),
        .o_head  (q_head),
        .o_valid (q_valid),
        .o_count (q_cnt)
    );

    // queue entries owed after this edge must leave room for the next read
    assign pop        = q_valid && i_m_tready;
    assign pend       = {1'b0, q_cnt} + {2'b0, push};
    assign o_s_tready = pend < (3'd2 + {2'b0, pop});
    assign o_m_tvalid = q_valid;
    assign o_m_tdata  = q_head;

    a_fwd_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |=> (r_w_valid && r_w_idx == $past(r_s1_idx)))
        else $error("forwarding register lost the last write");

    a_add_inrange: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> r_s1_inrange)
        else $error("add beat with bucket outside the table");

    a_read_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> o_m_tvalid)
        else $error("read beat did not reach the master port");

    a_written_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |=> r_vld[$past(r_s1_idx)])
        else $error("written bucket not marked valid");

endmodule

/* tb/log2_latency_histogram_tb.sv */
// Self-checking testbench for log2_latency_histogram: stream driver, result monitor and
// an in-bench histogram predictor that computes every read beat ahead of the block.
// Depends on l2h_pkg and the RTL of the block.
module log2_latency_histogram_tb;
    import l2h_pkg::*;

    typedef struct {
        logic             mode;
        logic [31:0]      sample;
        logic [SEL_W-1:0] sel;
        bit               wait_idle;  // hold this beat back until no result is outstanding
    } t_hist_req;

    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       i_s_tvalid = 1'b0;
    logic                       o_s_tready;
    logic [IN_DATA_W-1:0]       i_s_tdata  = '0;
    logic                       i_s_tuser  = 1'b0;
    logic                       o_m_tvalid;
    logic                       i_m_tready = 1'b0;
    logic [$bits(t_result)-1:0] o_m_tdata;

    // predicted histogram contents
    logic [CNT_W-1:0] bkt_count [NBUCKETS];
    logic [SUM_W-1:0] bkt_sum   [NBUCKETS];
    logic [CNT_W-1:0] grand_count;
    logic [SUM_W-1:0] grand_sum;

    t_hist_req   pending_beats [$];
    t_result     expected_reads [$];
    t_hist_req   cur_beat   = '{MODE_ADD, 32'd0, 6'd0, 1'b0};
    bit          offering   = 1'b0;
    int          gap_left   = 0;
    int          stall_left = 0;
    logic        hold_sink  = 1'b0;
    int unsigned cyc        = 0;
    int          beats_in   = 0;
    int          n_directed = 0;
    int          n_total    = 0;
    int          err_count  = 0;
    t_result     got_res;
    t_result     want_res;

    log2_latency_histogram dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        err_count++;
    endtask

    function automatic logic [CNT_W-1:0] cnt_bump(input logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

    function automatic logic [SUM_W-1:0] sum_acc(input logic [SUM_W-1:0] a,
                                                 input logic [31:0] s);
        logic [SUM_W:0] t;
        t = {1'b0, a} + (SUM_W + 1)'(s);
        return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
    endfunction

    // mostly short gaps, a few long ones; every fourth block of 50 beats runs without gaps
    function automatic int draw_gap(input int n);
        int r;
        if ((n / 50) % 4 == 1) return 0;
        r = $urandom_range(99, 0);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // random sample whose bit length is exactly oct
    function automatic logic [31:0] octave_sample(input int oct);
        logic [31:0] top;
        if (oct == 0) return 32'd0;
        top = 32'd1 << (oct - 1);
        return top | ($urandom & (top - 1));
    endfunction

    function automatic t_hist_req beat_of(input logic m, input logic [31:0] s,
                                          input logic [SEL_W-1:0] sel);
        t_hist_req r;
        r = '{m, s, sel, 1'b0};
        return r;
    endfunction

    function automatic t_hist_req random_add();
        logic [31:0] s;
        s = ($urandom_range(99, 0) < 80) ? octave_sample($urandom_range(32, 0)) : $urandom;
        return beat_of(MODE_ADD, s, SEL_W'($urandom));
    endfunction

    // histogram predictor: updates the bins on an add, queues the read-back on a read
    task automatic histo_apply(input t_hist_req r);
        logic [31:0] s;
        logic [31:0] v;
        int          oct;
        t_result     res;
        s = r.sample & SMP_MASK;
        if (r.mode == MODE_ADD) begin
            oct = 0;
            v   = s;
            while (v != 0) begin
                oct++;
                v = v >> 1;
            end
            if (oct < NBUCKETS) begin
                bkt_count[oct] = cnt_bump(bkt_count[oct]);
                bkt_sum[oct]   = sum_acc(bkt_sum[oct], s);
            end
            grand_count = cnt_bump(grand_count);
            grand_sum   = sum_acc(grand_sum, s);
        end else begin
            if (r.sel < NBUCKETS) begin
                res.bucket_count = bkt_count[r.sel];
                res.bucket_sum   = bkt_sum[r.sel];
            end else begin
                res.bucket_count = '0;
                res.bucket_sum   = '0;
            end
            res.all_count = grand_count;
            res.all_sum   = grand_sum;
            expected_reads.push_back(res);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NBUCKETS; b++) begin
                bkt_count[b] = '0;
                bkt_sum[b]   = '0;
            end
            grand_count = '0;
            grand_sum   = '0;
            offering    = 1'b0;
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                histo_apply(cur_beat);
                beats_in++;
                offering = 1'b0;
                gap_left = draw_gap(beats_in);
            end
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_beats.size() > 0 &&
                             !(pending_beats[0].wait_idle && expected_reads.size() != 0)) begin
                    cur_beat = pending_beats.pop_front();
                    offering = 1'b1;
                end
            end
            i_s_tvalid <= offering;
            i_s_tdata  <= {2'b00, cur_beat.sel, cur_beat.sample};
            i_s_tuser  <= cur_beat.mode;
        end
    end

    // monitor and sink backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            cyc++;
            if (o_m_tvalid && i_m_tready) begin
                got_res = t_result'(o_m_tdata);
                if (expected_reads.size() == 0) begin
                    report_mismatch($sformatf("unexpected result beat %h", o_m_tdata));
                end else begin
                    want_res = expected_reads.pop_front();
                    if (got_res.bucket_count !== want_res.bucket_count)
                        report_mismatch($sformatf("bucket_count got %0d want %0d",
                                                  got_res.bucket_count, want_res.bucket_count));
                    if (got_res.bucket_sum !== want_res.bucket_sum)
                        report_mismatch($sformatf("bucket_sum got %0d want %0d",
                                                  got_res.bucket_sum, want_res.bucket_sum));
                    if (got_res.all_count !== want_res.all_count)
                        report_mismatch($sformatf("all_count got %0d want %0d",
                                                  got_res.all_count, want_res.all_count));
                    if (got_res.all_sum !== want_res.all_sum)
                        report_mismatch($sformatf("all_sum got %0d want %0d",
                                                  got_res.all_sum, want_res.all_sum));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
            end else if (cyc % 1024 >= 256 && $urandom_range(99, 0) < 20) begin
                stall_left = draw_gap(0);
            end
            i_m_tready <= !hold_sink && stall_left == 0;
        end
    end

    // long sink hold-off right after the directed beats, while reads keep coming
    initial begin
        while (n_directed == 0 || beats_in < n_directed) @(posedge i_clk);
        hold_sink <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_sink <= 1'b0;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_hist_req r;
        int        pick;
        int        oct;
        int        n_rand_end;

        // empty histogram, in-range and out-of-range selects
        pending_beats.push_back(beat_of(MODE_READ, 32'hFFFF_FFFF, 6'd0));
        pending_beats.push_back(beat_of(MODE_READ, 32'h0000_0000, 6'd32));
        pending_beats.push_back(beat_of(MODE_READ, 32'hFFFF_FFFF, 6'd33));
        pending_beats.push_back(beat_of(MODE_READ, 32'h0000_0000, 6'd63));
        // octave edges and the extremes of the sample
        pending_beats.push_back(beat_of(MODE_ADD, 32'd0, 6'd63));
        pending_beats.push_back(beat_of(MODE_ADD, 32'd1, 6'd0));
        pending_beats.push_back(beat_of(MODE_ADD, 32'd2, 6'd42));
        pending_beats.push_back(beat_of(MODE_ADD, 32'd3, 6'd21));
        pending_beats.push_back(beat_of(MODE_ADD, 32'd4, 6'd0));
        pending_beats.push_back(beat_of(MODE_ADD, 32'h7FFF_FFFF, 6'd0));
        pending_beats.push_back(beat_of(MODE_ADD, 32'h8000_0000, 6'd0));
        pending_beats.push_back(beat_of(MODE_ADD, 32'hFFFF_FFFF, 6'd63));
        pending_beats.push_back(beat_of(MODE_ADD, 32'hFFFF_FFFF, 6'd63));
        pending_beats.push_back(beat_of(MODE_READ, 32'h5555_5555, 6'd0));
        pending_beats.push_back(beat_of(MODE_READ, 32'hAAAA_AAAA, 6'd1));
        pending_beats.push_back(beat_of(MODE_READ, 32'h0, 6'd2));
        pending_beats.push_back(beat_of(MODE_READ, 32'h0, 6'd3));
        pending_beats.push_back(beat_of(MODE_READ, 32'h0, 6'd31));
        pending_beats.push_back(beat_of(MODE_READ, 32'h0, 6'd32));
        pending_beats.push_back(beat_of(MODE_READ, 32'h0, 6'd42));
        pending_beats.push_back(beat_of(MODE_READ, 32'h0, 6'd21));
        pending_beats.push_back(beat_of(MODE_READ, 32'h0, 6'd63));
        // same bucket hit on consecutive beats, then read back
        pending_beats.push_back(beat_of(MODE_ADD, 32'd5, 6'd0));
        pending_beats.push_back(beat_of(MODE_ADD, 32'd6, 6'd0));
        pending_beats.push_back(beat_of(MODE_READ, 32'd0, 6'd3));
        n_directed = pending_beats.size();

        // read-heavy run to fill the block while the sink holds off
        for (int k = 0; k < 64; k++) begin
            if (k % 4 == 3) pending_beats.push_back(random_add());
            else pending_beats.push_back(beat_of(MODE_READ, $urandom,
                                                 SEL_W'($urandom_range(40, 0))));
        end

        n_rand_end = pending_beats.size() + 310;
        while (pending_beats.size() < n_rand_end) begin
            pick = $urandom_range(99, 0);
            if (pick < 55) begin
                r = random_add();
            end else if (pick < 75) begin
                // burst into one bucket, read back immediately
                oct = $urandom_range(32, 0);
                repeat ($urandom_range(4, 2))
                    pending_beats.push_back(beat_of(MODE_ADD, octave_sample(oct),
                                                    SEL_W'($urandom)));
                r = beat_of(MODE_READ, $urandom, SEL_W'(oct));
            end else begin
                r = beat_of(MODE_READ, $urandom,
                            ($urandom_range(99, 0) < 85) ? SEL_W'($urandom_range(32, 0))
                                                         : SEL_W'($urandom_range(63, 33)));
            end
            // sender pauses until all reads have drained, at two points along the way
            if (pending_beats.size() == n_directed + 64 ||
                (pending_beats.size() >= n_rand_end - 200 &&
                 pending_beats.size() < n_rand_end - 195))
                r.wait_idle = 1'b1;
            pending_beats.push_back(r);
        end
        n_total = pending_beats.size();

        while (beats_in < n_total) @(posedge i_clk);
        while (expected_reads.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/l2h_pkg.sv
rtl/l2h_ram.sv
rtl/l2h_outq.sv
rtl/log2_latency_histogram.sv
tb/log2_latency_histogram_tb.sv
